// ===== rtl/mcps_pkg.sv =====
`default_nettype none

package mcps_pkg;

    typedef enum logic [0:0] {
        OP_STEP  = 1'b0,
        OP_RESET = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ACT_LEFT  = 2'd0,
        ACT_COAST = 2'd1,
        ACT_RIGHT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_REWARD_PER_STEP = 2'd0,
        REG_REWARD_AT_GOAL  = 2'd1,
        REG_MAX_EPISODE_LEN = 2'd2
    } cfg_reg_t;

    localparam int POS_W   = 15;
    localparam int VEL_W   = 11;
    localparam int CNT_W   = 16;
    localparam int RWD_W   = 9;
    localparam int IDX_W   = 6;
    localparam int PULL_W  = 6;

    localparam logic signed [11:0]      PUSH_FORCE     = 12'sd10;
    localparam logic signed [11:0]      VEL_LIMIT_HI   = 12'sd700;
    localparam logic signed [11:0]      VEL_LIMIT_LO   = -12'sd700;
    localparam logic signed [15:0]      POS_HIGH       = 16'sd6000;
    localparam logic signed [15:0]      POS_LOW        = -16'sd12000;
    localparam logic signed [15:0]      POS_GOAL       = 16'sd5000;
    localparam logic signed [POS_W-1:0] START_BIAS     = 15'sd6000;
    localparam int                      TABLE_SHIFT    = 9;
    localparam logic [6:0]              TABLE_LAST     = 7'd35;

    localparam logic signed [7:0]  RESET_REWARD_PER_STEP = -8'sd1;
    localparam logic signed [7:0]  RESET_REWARD_AT_GOAL  = 8'sd100;
    localparam logic [CNT_W-1:0]   RESET_MAX_EPISODE_LEN = 16'd200;

    // Gravity pull along the track, one entry per 512 position units.
    function automatic logic signed [PULL_W-1:0] slope_pull(input logic [IDX_W-1:0] idx);
        logic signed [PULL_W-1:0] pull;
        case (idx)
            6'd0:    pull = 6'sd23;
            6'd1:    pull = 6'sd24;
            6'd2:    pull = 6'sd24;
            6'd3:    pull = 6'sd24;
            6'd4:    pull = 6'sd24;
            6'd5:    pull = 6'sd23;
            6'd6:    pull = 6'sd21;
            6'd7:    pull = 6'sd19;
            6'd8:    pull = 6'sd16;
            6'd9:    pull = 6'sd13;
            6'd10:   pull = 6'sd10;
            6'd11:   pull = 6'sd6;
            6'd12:   pull = 6'sd2;
            6'd13:   pull = -6'sd1;
            6'd14:   pull = -6'sd4;
            6'd15:   pull = -6'sd8;
            6'd16:   pull = -6'sd12;
            6'd17:   pull = -6'sd15;
            6'd18:   pull = -6'sd18;
            6'd19:   pull = -6'sd20;
            6'd20:   pull = -6'sd22;
            6'd21:   pull = -6'sd23;
            6'd22:   pull = -6'sd24;
            6'd23:   pull = -6'sd24;
            6'd24:   pull = -6'sd24;
            6'd25:   pull = -6'sd23;
            6'd26:   pull = -6'sd22;
            6'd27:   pull = -6'sd20;
            6'd28:   pull = -6'sd17;
            6'd29:   pull = -6'sd14;
            6'd30:   pull = -6'sd11;
            6'd31:   pull = -6'sd8;
            6'd32:   pull = -6'sd4;
            6'd33:   pull = 6'sd0;
            6'd34:   pull = 6'sd3;
            6'd35:   pull = 6'sd6;
            default: pull = 6'sd6;
        endcase
        return pull;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mountain_car_physics_step_top.sv =====
// Channel   Direction  Handshake               Payload
// in        request    in_valid / in_ready     opcode, action, start_offset
// out       result     out_valid / out_ready   reward, episode_done, car_position, car_velocity
// cfg       write      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each request is combinational: the full step is computed from the car state and the
// request fields and lands in the result register at the accepting edge.
// A new request is accepted every cycle while the result register is empty or being drained.
// When out_ready is low with a result waiting, in_ready drops until that result is taken.
// Reset clears the car state and loads the default configuration; cfg_ready is always high.
`default_nettype none

module mountain_car_physics_step_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [0:0]                    opcode,
    input  wire logic [1:0]                    action,
    input  wire logic [10:0]                   start_offset,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [mcps_pkg::RWD_W-1:0]  reward,
    output logic                               episode_done,
    output logic signed [mcps_pkg::POS_W-1:0]  car_position,
    output logic signed [mcps_pkg::VEL_W-1:0]  car_velocity,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [15:0]                   cfg_data
);

    logic signed [7:0]                     reward_per_step_reg;
    logic signed [7:0]                     reward_at_goal_reg;
    logic [mcps_pkg::CNT_W-1:0]            max_episode_len_reg;

    logic signed [mcps_pkg::POS_W-1:0]     position_reg, position_next;
    logic signed [mcps_pkg::VEL_W-1:0]     velocity_reg, velocity_next;
    logic [mcps_pkg::CNT_W-1:0]            step_count_reg, step_count_next;
    logic                                  done_reg, done_next;

    logic                                  out_valid_reg;
    logic signed [mcps_pkg::RWD_W-1:0]     reward_reg, reward_next;
    logic                                  in_accept;

    logic signed [11:0]                    vel_push;
    logic signed [11:0]                    vel_grav;
    logic signed [mcps_pkg::VEL_W-1:0]     vel_clamp;
    logic signed [15:0]                    idx_sum;
    logic [mcps_pkg::IDX_W-1:0]            table_idx;
    logic signed [mcps_pkg::PULL_W-1:0]    pull;
    logic signed [15:0]                    pos_sum;
    logic                                  at_goal;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reward_per_step_reg <= mcps_pkg::RESET_REWARD_PER_STEP;
            reward_at_goal_reg  <= mcps_pkg::RESET_REWARD_AT_GOAL;
            max_episode_len_reg <= mcps_pkg::RESET_MAX_EPISODE_LEN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (mcps_pkg::cfg_reg_t'(cfg_index))
                mcps_pkg::REG_REWARD_PER_STEP: reward_per_step_reg <= $signed(cfg_data[7:0]);
                mcps_pkg::REG_REWARD_AT_GOAL:  reward_at_goal_reg  <= $signed(cfg_data[7:0]);
                mcps_pkg::REG_MAX_EPISODE_LEN: max_episode_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Velocity update: push, then gravity from the slope under the current position.
    always_comb
    begin
        case (action)
            mcps_pkg::ACT_LEFT:  vel_push = 12'(velocity_reg) - mcps_pkg::PUSH_FORCE;
            mcps_pkg::ACT_RIGHT: vel_push = 12'(velocity_reg) + mcps_pkg::PUSH_FORCE;
            default:             vel_push = 12'(velocity_reg);
        endcase

        idx_sum = 16'(position_reg) - mcps_pkg::POS_LOW;
        if (idx_sum[15])
            table_idx = '0;
        else if (idx_sum[15:mcps_pkg::TABLE_SHIFT] > mcps_pkg::TABLE_LAST)
            table_idx = mcps_pkg::IDX_W'(mcps_pkg::TABLE_LAST);
        else
            table_idx = idx_sum[mcps_pkg::TABLE_SHIFT +: mcps_pkg::IDX_W];
        pull = mcps_pkg::slope_pull(table_idx);

        vel_grav = vel_push + 12'(pull);
        if (vel_grav > mcps_pkg::VEL_LIMIT_HI)
            vel_clamp = mcps_pkg::VEL_W'(mcps_pkg::VEL_LIMIT_HI);
        else if (vel_grav < mcps_pkg::VEL_LIMIT_LO)
            vel_clamp = mcps_pkg::VEL_W'(mcps_pkg::VEL_LIMIT_LO);
        else
            vel_clamp = vel_grav[mcps_pkg::VEL_W-1:0];

        pos_sum = 16'(position_reg) + 16'(vel_clamp);
    end

    // Next state and result for the request at the input.
    always_comb
    begin
        position_next   = position_reg;
        velocity_next   = velocity_reg;
        step_count_next = step_count_reg;
        done_next       = done_reg;
        reward_next     = '0;
        at_goal         = 1'b0;

        if (opcode == mcps_pkg::OP_RESET)
        begin
            position_next   = $signed({4'b0, start_offset}) - mcps_pkg::START_BIAS;
            velocity_next   = '0;
            step_count_next = '0;
            done_next       = 1'b0;
        end
        else
        begin
            // Hitting either wall stops the car.
            if (pos_sum > mcps_pkg::POS_HIGH)
            begin
                position_next = mcps_pkg::POS_W'(mcps_pkg::POS_HIGH);
                velocity_next = '0;
            end
            else if (pos_sum < mcps_pkg::POS_LOW)
            begin
                position_next = mcps_pkg::POS_W'(mcps_pkg::POS_LOW);
                velocity_next = '0;
            end
            else
            begin
                position_next = pos_sum[mcps_pkg::POS_W-1:0];
                velocity_next = vel_clamp;
            end

            if (step_count_reg != '1)
                step_count_next = step_count_reg + 1'b1;

            at_goal     = 16'(position_next) >= mcps_pkg::POS_GOAL;
            reward_next = mcps_pkg::RWD_W'(reward_per_step_reg)
                        + (at_goal ? mcps_pkg::RWD_W'(reward_at_goal_reg) : '0);
            if (at_goal || step_count_next >= max_episode_len_reg)
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            velocity_reg   <= '0;
            step_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else if (in_accept)
        begin
            position_reg   <= position_next;
            velocity_reg   <= velocity_next;
            step_count_reg <= step_count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            reward_reg <= reward_next;
    end

    // The result carries the state just written, so position, velocity and done come
    // straight from the state registers.
    assign out_valid    = out_valid_reg;
    assign reward       = reward_reg;
    assign episode_done = done_reg;
    assign car_position = position_reg;
    assign car_velocity = velocity_reg;

`ifndef NO_ASSERTIONS
    velocity_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (velocity_reg <= 11'sd700) && (velocity_reg >= -11'sd700))
        else $error("velocity left its clamp range");

    position_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (16'(position_reg) <= mcps_pkg::POS_HIGH) && (16'(position_reg) >= mcps_pkg::POS_LOW))
        else $error("position left the track");

    reset_request_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && opcode == mcps_pkg::OP_RESET)
        |=> (out_valid && !episode_done && reward == '0 && car_velocity == '0))
        else $error("episode reset produced a wrong result");

    done_is_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && opcode == mcps_pkg::OP_STEP && done_reg) |=> episode_done)
        else $error("done flag cleared by a step");
`endif

endmodule

`default_nettype wire
